// ===== src/kpec_pkg.sv =====
package kpec_pkg;

  localparam int NUM_KEYS_DEF = 5;
  localparam int LEVELS_W     = 5;
  localparam int TIME_W       = 32;
  localparam int CFG_W        = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int INDEX_W      = 3;
  localparam int CODE_W       = 3;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST      = CFG_W'(2000);
  localparam logic [CFG_W-1:0] LONG_LONG_PRESS_RST = CFG_W'(5000);
  localparam logic [CFG_W-1:0] REPEAT_RST          = CFG_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS      = 2'd0,
    REG_LONG_LONG_PRESS = 2'd1,
    REG_REPEAT          = 2'd2
  } kpec_reg_t;

  typedef enum logic [CODE_W-1:0] {
    EV_SHORT_PRESS       = 3'd0,
    EV_SHORT_RELEASE     = 3'd1,
    EV_LONG_PRESS        = 3'd2,
    EV_LONG_RELEASE      = 3'd3,
    EV_LONG_LONG_PRESS   = 3'd4,
    EV_LONG_LONG_RELEASE = 3'd5,
    EV_REPEAT            = 3'd6
  } kpec_event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } kpec_state_t;

  typedef struct packed {
    logic              held;
    logic              long_f;
    logic              long_long_f;
    logic [TIME_W-1:0] press_start;
    logic [TIME_W-1:0] repeat_start;
  } kpec_key_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] long_long_press_ms;
    logic [CFG_W-1:0] repeat_ms;
  } kpec_cfg_t;

endpackage

// ===== src/kpec_if.sv =====
interface kpec_in_if;
  logic                           valid;
  logic                           ready;
  logic [kpec_pkg::LEVELS_W-1:0]  key_levels;
  logic [kpec_pkg::TIME_W-1:0]    now_ms;

  modport source (output valid, key_levels, now_ms, input ready);
  modport sink   (input valid, key_levels, now_ms, output ready);
endinterface

interface kpec_out_if;
  logic                          valid;
  logic                          ready;
  logic [kpec_pkg::INDEX_W-1:0]  key_index;
  logic [kpec_pkg::CODE_W-1:0]   event_code;
  logic                          last_of_scan;

  modport source (output valid, key_index, event_code, last_of_scan, input ready);
  modport sink   (input valid, key_index, event_code, last_of_scan, output ready);
endinterface

// ===== src/kpec_classify.sv =====
module kpec_classify (
  input  kpec_pkg::kpec_key_t             key_cur,
  input  logic                            pressed,
  input  logic [kpec_pkg::TIME_W-1:0]     now_ms,
  input  kpec_pkg::kpec_cfg_t             cfg,
  output kpec_pkg::kpec_key_t             key_nxt,
  output logic                            ev_valid,
  output kpec_pkg::kpec_event_t           ev_code
);

  logic [kpec_pkg::TIME_W-1:0] since_press;
  logic [kpec_pkg::TIME_W-1:0] since_rep;

  // wrapping elapsed times
  assign since_press = now_ms - key_cur.press_start;
  assign since_rep   = now_ms - key_cur.repeat_start;

  always_comb begin
    key_nxt  = key_cur;
    ev_valid = 1'b0;
    ev_code  = kpec_pkg::EV_SHORT_PRESS;
    if (!key_cur.held) begin
      if (pressed) begin
        key_nxt.held        = 1'b1;
        key_nxt.press_start = now_ms;
        key_nxt.long_f      = 1'b0;
        ev_valid            = 1'b1;
        ev_code             = kpec_pkg::EV_SHORT_PRESS;
      end
    end else if (!pressed) begin
      if (key_cur.long_long_f) begin
        ev_code = kpec_pkg::EV_LONG_LONG_RELEASE;
      end else if (key_cur.long_f) begin
        ev_code = kpec_pkg::EV_LONG_RELEASE;
      end else begin
        ev_code = kpec_pkg::EV_SHORT_RELEASE;
      end
      key_nxt.held        = 1'b0;
      key_nxt.long_f      = 1'b0;
      key_nxt.long_long_f = 1'b0;
      ev_valid            = 1'b1;
    end else if (key_cur.long_f &&
                 (since_rep > kpec_pkg::TIME_W'(cfg.repeat_ms))) begin
      key_nxt.repeat_start = now_ms;
      ev_valid             = 1'b1;
      ev_code              = kpec_pkg::EV_REPEAT;
    end else if (!key_cur.long_f &&
                 (since_press > kpec_pkg::TIME_W'(cfg.long_press_ms))) begin
      key_nxt.long_f       = 1'b1;
      key_nxt.repeat_start = now_ms;
      ev_valid             = 1'b1;
      ev_code              = kpec_pkg::EV_LONG_PRESS;
    end else if (!key_cur.long_long_f &&
                 (since_press > kpec_pkg::TIME_W'(cfg.long_long_press_ms))) begin
      key_nxt.long_long_f = 1'b1;
      ev_valid            = 1'b1;
      ev_code             = kpec_pkg::EV_LONG_LONG_PRESS;
    end
  end

endmodule

// ===== src/kpec_key_store.sv =====
module kpec_key_store #(
  parameter int NUM_KEYS = kpec_pkg::NUM_KEYS_DEF,
  parameter int IDX_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IDX_W-1:0]     idx,
  input  logic                 wr_en,
  input  kpec_pkg::kpec_key_t  wr_data,
  output kpec_pkg::kpec_key_t  rd_data
);

  kpec_pkg::kpec_key_t keys_r [NUM_KEYS];

  assign rd_data = keys_r[idx];

  // flags reset, time stamps are only read once a flag says they were written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        keys_r[k].held        <= 1'b0;
        keys_r[k].long_f      <= 1'b0;
        keys_r[k].long_long_f <= 1'b0;
      end
    end else if (wr_en) begin
      keys_r[idx] <= wr_data;
    end
  end

endmodule

// ===== src/key_press_event_classifier_unit.sv =====
// channel  | dir | word                                   | handshake
// in_if    | in  | key_levels[4:0], now_ms[31:0]          | valid/ready
// out_if   | out | key_index[2:0], event_code[2:0], last  | valid/ready
// cfg_*    | in  | cfg_index[1:0], cfg_wdata[23:0]        | write enable only
//
// a scan accepts the input word, then walks one key per cycle through the shared
// classifier unless the walk stalls, then flushes the held back last event; the
// per-key classify step (two subtracts and compares) is combinational
// in_if.ready is high only while idle, one scan at a time
// a found event waits in a one-entry holding stage so the last word of a scan
// can be flagged; the key walk stalls only when a new event is found while that
// stage and the output register are both full and out_if.ready is low
// rst_n is synchronous, active low: clears the key flags and loads the
// default thresholds
module key_press_event_classifier_unit #(
  parameter int NUM_KEYS = kpec_pkg::NUM_KEYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  kpec_in_if.sink                         in_if,
  kpec_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [kpec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpec_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  kpec_pkg::kpec_state_t state_r, state_nxt;

  // threshold registers
  kpec_pkg::kpec_cfg_t cfg_r;

  // latched scan
  logic [kpec_pkg::LEVELS_W-1:0] levels_r;
  logic [kpec_pkg::TIME_W-1:0]   now_r;
  logic [IDX_W-1:0]              key_r;

  // holding stage for the newest event
  logic                          pend_v_r;
  logic [kpec_pkg::INDEX_W-1:0]  pend_idx_r;
  kpec_pkg::kpec_event_t         pend_code_r;

  // output register
  logic                          out_v_r;
  logic [kpec_pkg::INDEX_W-1:0]  out_idx_r;
  kpec_pkg::kpec_event_t         out_code_r;
  logic                          out_last_r;

  kpec_pkg::kpec_key_t   key_cur;
  kpec_pkg::kpec_key_t   key_nxt;
  logic                  ev_valid;
  kpec_pkg::kpec_event_t ev_code;

  logic        in_take;
  logic        out_free;
  logic        adv;
  logic        push_mid;
  logic        push_last;
  logic        last_key;
  logic        pressed;
  logic [31:0] key_ext;
  logic [7:0]  levels_ext;

  assign in_take    = in_if.valid && in_if.ready;
  assign out_free   = !out_v_r || out_if.ready;
  assign last_key   = (key_r == IDX_W'(NUM_KEYS - 1));
  assign key_ext    = 32'(key_r);
  assign levels_ext = 8'(levels_r);
  // keys past the level field read as released
  assign pressed    = (key_ext < 32'(kpec_pkg::LEVELS_W)) && levels_ext[key_ext[2:0]];

  kpec_key_store #(
    .NUM_KEYS (NUM_KEYS),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .idx     (key_r),
    .wr_en   (adv),
    .wr_data (key_nxt),
    .rd_data (key_cur)
  );

  kpec_classify u_classify (
    .key_cur  (key_cur),
    .pressed  (pressed),
    .now_ms   (now_r),
    .cfg      (cfg_r),
    .key_nxt  (key_nxt),
    .ev_valid (ev_valid),
    .ev_code  (ev_code)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kpec_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = kpec_pkg::ST_SCAN;
        end
      end
      kpec_pkg::ST_SCAN: begin
        if (adv && last_key) begin
          state_nxt = kpec_pkg::ST_FLUSH;
        end
      end
      kpec_pkg::ST_FLUSH: begin
        if (!pend_v_r || out_free) begin
          state_nxt = kpec_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kpec_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_if.ready = 1'b0;
    adv         = 1'b0;
    push_mid    = 1'b0;
    push_last   = 1'b0;
    case (state_r)
      kpec_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
      end
      kpec_pkg::ST_SCAN: begin
        // a new event with a full holding stage needs room downstream
        adv      = !(ev_valid && pend_v_r && !out_free);
        push_mid = adv && ev_valid && pend_v_r;
      end
      kpec_pkg::ST_FLUSH: begin
        push_last = pend_v_r && out_free;
      end
      default: begin
        in_if.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kpec_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms      <= kpec_pkg::LONG_PRESS_RST;
      cfg_r.long_long_press_ms <= kpec_pkg::LONG_LONG_PRESS_RST;
      cfg_r.repeat_ms          <= kpec_pkg::REPEAT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kpec_pkg::REG_LONG_PRESS:      cfg_r.long_press_ms      <= cfg_wdata;
        kpec_pkg::REG_LONG_LONG_PRESS: cfg_r.long_long_press_ms <= cfg_wdata;
        kpec_pkg::REG_REPEAT:          cfg_r.repeat_ms          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // scan latch and key walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (in_take) begin
      key_r <= '0;
    end else if (adv && !last_key) begin
      key_r <= key_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      levels_r <= in_if.key_levels;
      now_r    <= in_if.now_ms;
    end
  end

  // holding stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (adv && ev_valid) begin
      pend_v_r <= 1'b1;
    end else if (push_last) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ev_valid) begin
      pend_idx_r  <= key_ext[kpec_pkg::INDEX_W-1:0];
      pend_code_r <= ev_code;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push_mid || push_last) begin
      out_v_r <= 1'b1;
    end else if (out_if.valid && out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_last) begin
      out_idx_r  <= pend_idx_r;
      out_code_r <= pend_code_r;
      out_last_r <= push_last;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.key_index    = out_idx_r;
  assign out_if.event_code   = out_code_r;
  assign out_if.last_of_scan = out_last_r;

endmodule
